@@ hw/rtl/bhv_pkg.sv @@
// Shared types and constants of the BMP header validator.
package bhv_pkg;

  // One input item: a header byte with the file length and the end marker.
  typedef struct packed {
    logic [7:0]  header_byte;
    logic [31:0] file_length;
    logic        end_of_header;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [31:0] pixel_offset;
    logic [17:0] row_bytes;
    logic [5:0]  bits_per_pixel;
    logic        rows_top_down;
  } out_item_t;

  // Result status codes, in the order the checks are made.
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_SIGNATURE  = 4'd2,
    ST_INFO_SIZE  = 4'd3,
    ST_PLANES     = 4'd4,
    ST_DEPTH      = 4'd5,
    ST_COMPRESSED = 4'd6,
    ST_WIDTH      = 4'd7,
    ST_HEIGHT     = 4'd8,
    ST_OFFSET     = 4'd9,
    ST_TRUNCATED  = 4'd10,
    ST_NOT_STRICT = 4'd11
  } status_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAX_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_STRICT     = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] MAX_WIDTH_RST  = 16'd128;
  localparam logic [15:0] MAX_HEIGHT_RST = 16'd128;

  // Header layout and limits.
  localparam logic [31:0] HDR_LEN    = 32'd54;
  localparam logic [5:0]  HDR_CNT    = 6'd54;
  localparam logic [5:0]  COUNT_MAX  = 6'd63;
  localparam logic [31:0] INFO_LEN   = 32'd40;
  localparam logic [7:0]  SIG_B      = 8'h42;
  localparam logic [7:0]  SIG_M      = 8'h4D;
  localparam logic [15:0] BPP_24     = 16'd24;
  localparam logic [15:0] BPP_32     = 16'd32;
  localparam logic [5:0]  OFS_OFFSET = 6'd10;
  localparam logic [5:0]  OFS_INFO   = 6'd14;
  localparam logic [5:0]  OFS_WIDTH  = 6'd18;
  localparam logic [5:0]  OFS_HEIGHT = 6'd22;
  localparam logic [5:0]  OFS_PLANES = 6'd26;
  localparam logic [5:0]  OFS_COMP   = 6'd30;
  localparam logic [5:0]  OFS_END    = 6'd34;

  // Captured header handed from the front part to the back part.
  typedef struct packed {
    logic [31:0] file_length;
    logic        count_ok;
    logic        sig_ok;
    logic [31:0] offset;
    logic [31:0] dib_size;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] planes_depth;
    logic [31:0] compression;
  } hdr_t;

  // Configuration seen by the back part.
  typedef struct packed {
    logic [15:0] max_width;
    logic [15:0] max_height;
    logic        strict_sprite;
  } cfg_t;

endpackage

@@ hw/rtl/bhv_front.sv @@
// Front part: byte capture of the header fields and the header queue.
module bhv_front import bhv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     q_valid,
  output hdr_t     q_data,
  input  logic     q_pop
);

  logic [5:0]  count_r, count_nxt;
  logic        sig_r, sig_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] info_r, info_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [31:0] pd_r, pd_nxt;
  logic [31:0] comp_r, comp_nxt;
  logic [1:0]  pos;
  logic [4:0]  bit_lo;
  logic [7:0]  b;
  logic        accept;
  logic        q_wr;
  logic        q_rd;
  hdr_t        snap;

  hdr_t        q_mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  q_cnt_r;

  assign accept = push && !full;
  assign b      = in_data.header_byte;
  // All field start offsets are 2 modulo 4, so the byte lane follows the count.
  assign pos    = count_r[1:0] - 2'd2;
  assign bit_lo = {pos, 3'b000};

  // Next values of the captured fields for the byte at hand.
  always_comb begin
    sig_nxt    = sig_r;
    offset_nxt = offset_r;
    info_nxt   = info_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    pd_nxt     = pd_r;
    comp_nxt   = comp_r;
    priority if (count_r == 6'd0) begin
      sig_nxt = (b == SIG_B);
    end else if (count_r == 6'd1) begin
      sig_nxt = sig_r && (b == SIG_M);
    end else if (count_r >= OFS_OFFSET && count_r < OFS_INFO) begin
      offset_nxt[bit_lo +: 8] = b;
    end else if (count_r >= OFS_INFO && count_r < OFS_WIDTH) begin
      info_nxt[bit_lo +: 8] = b;
    end else if (count_r >= OFS_WIDTH && count_r < OFS_HEIGHT) begin
      width_nxt[bit_lo +: 8] = b;
    end else if (count_r >= OFS_HEIGHT && count_r < OFS_PLANES) begin
      height_nxt[bit_lo +: 8] = b;
    end else if (count_r >= OFS_PLANES && count_r < OFS_COMP) begin
      pd_nxt[bit_lo +: 8] = b;
    end else if (count_r >= OFS_COMP && count_r < OFS_END) begin
      comp_nxt[bit_lo +: 8] = b;
    end else begin
      sig_nxt = sig_r;
    end
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 6'd1;
  end

  // Snapshot of the header including the byte that ends it.
  always_comb begin
    snap.file_length  = in_data.file_length;
    snap.count_ok     = (count_nxt >= HDR_CNT);
    snap.sig_ok       = sig_nxt;
    snap.offset       = offset_nxt;
    snap.dib_size     = info_nxt;
    snap.width        = width_nxt;
    snap.height       = height_nxt;
    snap.planes_depth = pd_nxt;
    snap.compression  = comp_nxt;
  end

  // Capture registers; the end of a header starts the next one from zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sig_r    <= 1'b0;
      offset_r <= '0;
      info_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      pd_r     <= '0;
      comp_r   <= '0;
    end else if (accept) begin
      if (in_data.end_of_header) begin
        count_r  <= '0;
        sig_r    <= 1'b0;
        offset_r <= '0;
        info_r   <= '0;
        width_r  <= '0;
        height_r <= '0;
        pd_r     <= '0;
        comp_r   <= '0;
      end else begin
        count_r  <= count_nxt;
        sig_r    <= sig_nxt;
        offset_r <= offset_nxt;
        info_r   <= info_nxt;
        width_r  <= width_nxt;
        height_r <= height_nxt;
        pd_r     <= pd_nxt;
        comp_r   <= comp_nxt;
      end
    end
  end

  // Two-entry queue of finished headers toward the back part.
  assign q_wr    = accept && in_data.end_of_header;
  assign q_rd    = q_pop && q_valid;
  assign full    = (q_cnt_r == 2'd2);
  assign q_valid = (q_cnt_r != 2'd0);
  assign q_data  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_wr) begin
      q_mem_r[wr_ptr_r] <= snap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= '0;
    end else begin
      if (q_wr) wr_ptr_r <= !wr_ptr_r;
      if (q_rd) rd_ptr_r <= !rd_ptr_r;
      if (q_wr && !q_rd) q_cnt_r <= q_cnt_r + 2'd1;
      else if (q_rd && !q_wr) q_cnt_r <= q_cnt_r - 2'd1;
    end
  end

endmodule

@@ hw/rtl/bhv_back.sv @@
// Back part: check pipeline, row size product and the result queue.
module bhv_back import bhv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  hdr_t      q_data,
  output logic      q_pop,
  output logic      empty,
  output out_item_t out_data,
  input  logic      pop
);

  // Stage A registers: checks up to the data offset, stride.
  logic        a_valid_r;
  logic [3:0]  a_status_r;
  logic [15:0] a_w_r, a_h_r;
  logic [31:0] a_off_r, a_len_r;
  logic [17:0] a_stride_r;
  logic [5:0]  a_bpp_r;
  logic        a_td_r, a_strict_r;

  // Stage B registers: stride times height.
  logic        b_valid_r;
  logic [3:0]  b_status_r;
  logic [15:0] b_w_r, b_h_r;
  logic [31:0] b_off_r, b_len_r;
  logic [17:0] b_stride_r;
  logic [5:0]  b_bpp_r;
  logic        b_td_r, b_strict_r;
  logic [33:0] b_prod_r;

  // Result queue.
  out_item_t   o_mem_r [2];
  logic        o_wr_ptr_r, o_rd_ptr_r;
  logic [1:0]  o_cnt_r;

  logic        o_full, o_wr, o_rd, a_rdy, b_rdy;
  logic [15:0] planes, bpp;
  logic        td;
  logic [31:0] habs;
  logic [15:0] w16;
  logic [17:0] prod3, prod, stride;
  logic        strict_fail;
  logic [3:0]  a_status_nxt;
  logic [34:0] need;
  logic [3:0]  fin_status;
  out_item_t   result;

  // Stall chain from the result queue back to the header queue.
  assign o_full = (o_cnt_r == 2'd2);
  assign b_rdy  = !b_valid_r || !o_full;
  assign a_rdy  = !a_valid_r || b_rdy;
  assign q_pop  = q_valid && a_rdy;

  // Stage A: field checks in status code order and the padded row size.
  assign planes = q_data.planes_depth[15:0];
  assign bpp    = q_data.planes_depth[31:16];
  assign td     = q_data.height[31];
  assign habs   = td ? (~q_data.height + 32'd1) : q_data.height;
  assign w16    = q_data.width[15:0];
  assign prod3  = {2'b00, w16} + {1'b0, w16, 1'b0};
  assign prod   = (bpp == BPP_32) ? {w16, 2'b00} : prod3;
  assign stride = (prod + 18'd3) & ~18'd3;
  assign strict_fail = cfg.strict_sprite && ((bpp != BPP_24) || td);

  always_comb begin
    priority if (q_data.file_length < HDR_LEN || !q_data.count_ok) begin
      a_status_nxt = ST_SHORT;
    end else if (!q_data.sig_ok) begin
      a_status_nxt = ST_SIGNATURE;
    end else if (q_data.dib_size != INFO_LEN) begin
      a_status_nxt = ST_INFO_SIZE;
    end else if (planes != 16'd1) begin
      a_status_nxt = ST_PLANES;
    end else if (bpp != BPP_24 && bpp != BPP_32) begin
      a_status_nxt = ST_DEPTH;
    end else if (q_data.compression != 32'd0) begin
      a_status_nxt = ST_COMPRESSED;
    end else if (q_data.width[31] || q_data.width == 32'd0 ||
                 q_data.width > {16'd0, cfg.max_width}) begin
      a_status_nxt = ST_WIDTH;
    end else if (habs[31] || habs == 32'd0 || habs > {16'd0, cfg.max_height}) begin
      a_status_nxt = ST_HEIGHT;
    end else if (q_data.offset < HDR_LEN || q_data.offset >= q_data.file_length) begin
      a_status_nxt = ST_OFFSET;
    end else begin
      a_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_rdy) begin
      a_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_status_r <= a_status_nxt;
      a_w_r      <= w16;
      a_h_r      <= habs[15:0];
      a_off_r    <= q_data.offset;
      a_len_r    <= q_data.file_length;
      a_stride_r <= stride;
      a_bpp_r    <= bpp[5:0];
      a_td_r     <= td;
      a_strict_r <= strict_fail;
    end
  end

  // Stage B: bytes taken by all rows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_rdy) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_status_r <= a_status_r;
      b_w_r      <= a_w_r;
      b_h_r      <= a_h_r;
      b_off_r    <= a_off_r;
      b_len_r    <= a_len_r;
      b_stride_r <= a_stride_r;
      b_bpp_r    <= a_bpp_r;
      b_td_r     <= a_td_r;
      b_strict_r <= a_strict_r;
      b_prod_r   <= a_stride_r * a_h_r;
    end
  end

  // Stage C: file size check, strict mode and zeroing on failure.
  assign need = {3'b000, b_off_r} + {1'b0, b_prod_r};

  always_comb begin
    priority if (b_status_r != ST_OK) begin
      fin_status = b_status_r;
    end else if (need > {3'b000, b_len_r}) begin
      fin_status = ST_TRUNCATED;
    end else if (b_strict_r) begin
      fin_status = ST_NOT_STRICT;
    end else begin
      fin_status = ST_OK;
    end
    result        = '0;
    result.status = fin_status;
    if (fin_status == ST_OK) begin
      result.image_width    = b_w_r;
      result.image_height   = b_h_r;
      result.pixel_offset   = b_off_r;
      result.row_bytes      = b_stride_r;
      result.bits_per_pixel = b_bpp_r;
      result.rows_top_down  = b_td_r;
    end
  end

  // Two-entry result queue.
  assign o_wr     = b_valid_r && !o_full;
  assign o_rd     = pop && !empty;
  assign empty    = (o_cnt_r == 2'd0);
  assign out_data = o_mem_r[o_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (o_wr) begin
      o_mem_r[o_wr_ptr_r] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_wr_ptr_r <= 1'b0;
      o_rd_ptr_r <= 1'b0;
      o_cnt_r    <= '0;
    end else begin
      if (o_wr) o_wr_ptr_r <= !o_wr_ptr_r;
      if (o_rd) o_rd_ptr_r <= !o_rd_ptr_r;
      if (o_wr && !o_rd) o_cnt_r <= o_cnt_r + 2'd1;
      else if (o_rd && !o_wr) o_cnt_r <= o_cnt_r - 2'd1;
    end
  end

endmodule

@@ hw/rtl/bmp_header_validator_unit.sv @@
// Top level of the BMP header validator: configuration registers and the two parts.
// Throughput: one header byte per cycle while full is low; one result per cycle at most.
// A result passes the header queue, the check stage, the row size multiply stage and
// the result queue write before it shows on the output; a full result queue stalls it.
// A two-entry header queue and a two-entry result queue decouple the two sides.
// Reset (rst_n low at a clock edge) clears the capture state and both queues and
// restores max_width and max_height to 128 and strict_sprite to 0.
module bmp_header_validator_unit import bhv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r;
  logic q_valid;
  logic q_pop;
  hdr_t q_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_width     <= MAX_WIDTH_RST;
      cfg_r.max_height    <= MAX_HEIGHT_RST;
      cfg_r.strict_sprite <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MAX_WIDTH:  cfg_r.max_width     <= cfg_wdata;
        CFG_MAX_HEIGHT: cfg_r.max_height    <= cfg_wdata;
        CFG_STRICT:     cfg_r.strict_sprite <= cfg_wdata[0];
        default:        cfg_r               <= cfg_r;
      endcase
    end
  end

  // Byte capture and header queue.
  bhv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  // Checks and result queue.
  bhv_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .out_data (out_data),
    .pop      (pop)
  );

endmodule

@@ hw/rtl/bhv_checker.sv @@
// Port-level assertions for the BMP header validator, bound to the top level.
module bhv_checker import bhv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  // Leaving reset, both queues are empty.
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> (empty && !full))
    else $error("queues not empty after reset");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.status <= ST_NOT_STRICT))
    else $error("status code out of range");

  // A failing item carries zeroed fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status != ST_OK) |->
      (out_data.image_width == 16'd0 && out_data.image_height == 16'd0 &&
       out_data.pixel_offset == 32'd0 && out_data.row_bytes == 18'd0 &&
       out_data.bits_per_pixel == 6'd0 && !out_data.rows_top_down))
    else $error("failing item has nonzero fields");

  // A good item has a supported depth, a nonzero size and a padded stride.
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_OK) |->
      ((out_data.bits_per_pixel == 6'd24 || out_data.bits_per_pixel == 6'd32) &&
       out_data.image_width != 16'd0 && out_data.image_height != 16'd0 &&
       out_data.row_bytes[1:0] == 2'b00 && out_data.pixel_offset >= HDR_LEN))
    else $error("good item has inconsistent fields");

  // A waiting item that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting item changed");

endmodule

bind bmp_header_validator_unit bhv_checker u_bhv_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
